[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the LET permeability block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define LRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also holds across reset.
`define LRP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/lrp_pkg.sv]
// ----------------------------------------------------------------------------
// LET relative permeability package
// Field widths, result classes, register indexes and the exp2 root table.
// ----------------------------------------------------------------------------
package lrp_pkg;

  // Fixed field widths.
  localparam int SAT_W     = 16;
  localparam int COEF_W    = 16;
  localparam int PERM_W    = 17;
  localparam int CFG_IDX_W = 8;

  // Internal Q.32 arithmetic for logarithm and power.
  localparam int Q_FRAC    = 32;
  localparam int POW_W     = Q_FRAC + 1;
  localparam int EXP_SHIFT = 12;
  localparam int TERM_W    = COEF_W + POW_W - EXP_SHIFT;
  localparam int SUM_W     = TERM_W + 1;

  // A power whose integer exponent part reaches this value is zero.
  localparam int POW_ZERO_SHIFT = 33;

  localparam logic [PERM_W-1:0] PERM_ONE = PERM_W'(65536);

  // Class of a sample, decided up front and refined after normalizing.
  typedef enum logic [1:0] {
    CLS_MID  = 2'd0,
    CLS_LOW  = 2'd1,
    CLS_HIGH = 2'd2,
    CLS_DEG  = 2'd3
  } lrp_class_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WATER_L     = 8'd0,
    REG_WATER_E     = 8'd1,
    REG_WATER_T     = 8'd2,
    REG_OIL_L       = 8'd3,
    REG_OIL_E       = 8'd4,
    REG_OIL_T       = 8'd5,
    REG_IRRED_WATER = 8'd6,
    REG_RESID_OIL   = 8'd7
  } lrp_reg_t;

  typedef logic [Q_FRAC-1:0][31:0] lrp_coef_tab_t;

  // Integer square root of a 64-bit value, bit by bit.
  function automatic logic [63:0] lrp_isqrt64(input logic [63:0] a);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_v;
    rem   = a;
    res   = '0;
    bit_v = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // Factors 2^(-2^-k) in Q.32, each the square root of the one before.
  function automatic lrp_coef_tab_t lrp_coef_build();
    lrp_coef_tab_t tab;
    logic [63:0]   c;
    c = lrp_isqrt64(64'h8000_0000_0000_0000);
    for (int k = 0; k < Q_FRAC; k++) begin
      tab[k] = c[31:0];
      c      = lrp_isqrt64({c[31:0], 32'h0});
    end
    return tab;
  endfunction

  localparam lrp_coef_tab_t EXP_COEF = lrp_coef_build();

endpackage

[design/lrp_ifs.sv]
// ----------------------------------------------------------------------------
// LET relative permeability channels
// Valid/ready interfaces for the sample, result and register-write channels.
// ----------------------------------------------------------------------------
interface lrp_in_if import lrp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SAT_W-1:0] water_saturation;

  modport source (output valid, output water_saturation, input ready);
  modport sink   (input valid, input water_saturation, output ready);
endinterface

interface lrp_out_if import lrp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PERM_W-1:0] water_perm;
  logic [PERM_W-1:0] oil_perm;
  logic              degenerate;

  modport source (output valid, output water_perm, output oil_perm, output degenerate,
                  input ready);
  modport sink   (input valid, input water_perm, input oil_perm, input degenerate,
                  output ready);
endinterface

interface lrp_cfg_if import lrp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/lrp_div.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, several lanes sharing one valid and sideband.
// The first stage compares without shifting, so the partial remainder must
// start below twice the divisor; later stages shift in zeros.
// ----------------------------------------------------------------------------
module lrp_div #(
  parameter int LANES = 1,
  parameter int DW    = 17,
  parameter int QW    = 17,
  parameter int SB_W  = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [SB_W-1:0]           in_sb,
  input  logic [LANES-1:0][DW-1:0]  in_rem,
  input  logic [LANES-1:0][DW-1:0]  in_div,
  output logic                      out_vld,
  output logic [SB_W-1:0]           out_sb,
  output logic [LANES-1:0][QW-1:0]  out_q
);

  logic [QW:0]                vld_r;
  logic [SB_W-1:0]            sb_r   [QW+1];
  logic [LANES-1:0][DW-1:0]   rem_r  [QW];
  logic [LANES-1:0][DW-1:0]   div_r  [QW];
  logic [LANES-1:0][QW-1:0]   q_r    [QW];
  logic [LANES-1:0][DW-1:0]   rem_nxt[QW];
  logic [LANES-1:0][QW-1:0]   q_nxt  [QW];

  // One compare and subtract per stage and lane.
  always_comb begin
    logic [DW:0]   cand;
    logic [QW-1:0] prev;
    for (int s = 0; s < QW; s++) begin
      for (int l = 0; l < LANES; l++) begin
        if (s == 0) begin
          cand = {1'b0, rem_r[s][l]};
          prev = '0;
        end else begin
          cand = {rem_r[s][l], 1'b0};
          prev = q_r[s-1][l];
        end
        if (cand >= {1'b0, div_r[s][l]}) begin
          rem_nxt[s][l] = DW'(cand - {1'b0, div_r[s][l]});
          q_nxt[s][l]   = {prev[QW-2:0], 1'b1};
        end else begin
          rem_nxt[s][l] = cand[DW-1:0];
          q_nxt[s][l]   = {prev[QW-2:0], 1'b0};
        end
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= in_rem;
      div_r[0] <= in_div;
      sb_r[0]  <= in_sb;
      for (int s = 0; s < QW; s++) begin
        q_r[s]    <= q_nxt[s];
        sb_r[s+1] <= sb_r[s];
      end
      for (int s = 0; s < QW - 1; s++) begin
        rem_r[s+1] <= rem_nxt[s];
        div_r[s+1] <= div_r[s];
      end
    end
  end

  // Valid bits travel with the payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-1:0], in_vld};
    end
  end

  assign out_vld = vld_r[QW];
  assign out_sb  = sb_r[QW];
  assign out_q   = q_r[QW-1];

endmodule

[design/lrp_log.sv]
// ----------------------------------------------------------------------------
// Pipelined negative base-2 logarithm
// Normalizes the fraction, then squares once per stage to produce one bit
// of the logarithm's fraction; the result is unsigned Q.32.
// ----------------------------------------------------------------------------
module lrp_log import lrp_pkg::*; #(
  parameter int LANES = 2,
  parameter int FB    = 16,
  parameter int LOG_W = 37,
  parameter int SB_W  = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [SB_W-1:0]             in_sb,
  input  logic [LANES-1:0][FB-1:0]    in_val,
  output logic                        out_vld,
  output logic [SB_W-1:0]             out_sb,
  output logic [LANES-1:0][LOG_W-1:0] out_lg
);

  localparam int NW  = $clog2(FB);
  localparam int STG = Q_FRAC + 3;
  localparam int HW  = LOG_W - Q_FRAC;

  logic [STG-1:0]              vld_r;
  logic [SB_W-1:0]             sb_r [STG];
  logic [LANES-1:0][FB-1:0]    val_r;
  logic [LANES-1:0][31:0]      m_r  [Q_FRAC];
  logic [LANES-1:0][NW-1:0]    n_r  [Q_FRAC+1];
  logic [LANES-1:0][31:0]      fr_r [Q_FRAC];
  logic [LANES-1:0][LOG_W-1:0] lg_r;

  logic [LANES-1:0][31:0]      m_nrm;
  logic [LANES-1:0][NW-1:0]    n_nrm;
  logic [LANES-1:0][31:0]      m_nxt [Q_FRAC];
  logic [LANES-1:0][31:0]      fr_nxt[Q_FRAC];
  logic [LANES-1:0][LOG_W-1:0] lg_nxt;

  // Normalize: shift the leading one up to bit 31.
  always_comb begin
    logic [NW-1:0] hp;
    for (int l = 0; l < LANES; l++) begin
      hp = '0;
      for (int i = 0; i < FB; i++) begin
        if (val_r[l][i]) begin
          hp = NW'(i);
        end
      end
      n_nrm[l] = NW'(FB - 1) - hp;
      m_nrm[l] = {val_r[l], {(32 - FB){1'b0}}} << n_nrm[l];
    end
  end

  // Squaring steps: each yields one fraction bit.
  always_comb begin
    logic [63:0] sq;
    logic [32:0] mm;
    logic [31:0] prev;
    for (int k = 0; k < Q_FRAC; k++) begin
      for (int l = 0; l < LANES; l++) begin
        sq   = {32'h0, m_r[k][l]} * {32'h0, m_r[k][l]};
        mm   = sq[63:31];
        prev = (k == 0) ? '0 : fr_r[k-1][l];
        fr_nxt[k][l] = {prev[30:0], mm[32]};
        m_nxt[k][l]  = mm[32] ? mm[32:1] : mm[31:0];
      end
    end
  end

  // Combine the integer part with the fraction.
  always_comb begin
    logic [HW-1:0] hi;
    for (int l = 0; l < LANES; l++) begin
      hi        = HW'(n_r[Q_FRAC][l]) + HW'(1);
      lg_nxt[l] = {hi, 32'h0} - LOG_W'(fr_r[Q_FRAC-1][l]);
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (en) begin
      val_r   <= in_val;
      m_r[0]  <= m_nrm;
      n_r[0]  <= n_nrm;
      sb_r[0] <= in_sb;
      for (int k = 0; k < Q_FRAC; k++) begin
        fr_r[k]  <= fr_nxt[k];
        n_r[k+1] <= n_r[k];
      end
      for (int k = 0; k < Q_FRAC - 1; k++) begin
        m_r[k+1] <= m_nxt[k];
      end
      for (int s = 0; s < STG - 1; s++) begin
        sb_r[s+1] <= sb_r[s];
      end
      lg_r <= lg_nxt;
    end
  end

  // Valid bits travel with the payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STG-2:0], in_vld};
    end
  end

  assign out_vld = vld_r[STG-1];
  assign out_sb  = sb_r[STG-1];
  assign out_lg  = lg_r;

endmodule

[design/lrp_pow.sv]
// ----------------------------------------------------------------------------
// Pipelined power evaluator
// Scales the negative logarithm by the Q4.12 exponent, then builds 2^-t in
// Q.32 from the square-root chain of 1/2, one factor per stage.
// ----------------------------------------------------------------------------
module lrp_pow import lrp_pkg::*; #(
  parameter int LANES = 4,
  parameter int LOG_W = 37,
  parameter int SB_W  = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [SB_W-1:0]              in_sb,
  input  logic [LANES-1:0][LOG_W-1:0]  in_lg,
  input  logic [LANES-1:0][COEF_W-1:0] in_p,
  output logic                         out_vld,
  output logic [SB_W-1:0]              out_sb,
  output logic [LANES-1:0][POW_W-1:0]  out_pw
);

  localparam int PW   = LOG_W + COEF_W;
  localparam int TW   = PW - EXP_SHIFT;
  localparam int TI_W = TW - Q_FRAC;
  localparam int STG  = Q_FRAC + 3;
  localparam logic [POW_W-1:0] POW_ONE = POW_W'(1) << Q_FRAC;

  logic [STG-1:0]               vld_r;
  logic [SB_W-1:0]              sb_r [STG];
  logic [LANES-1:0][LOG_W-1:0]  lg_r;
  logic [LANES-1:0][COEF_W-1:0] p_r;
  logic [LANES-1:0][Q_FRAC-1:0] tf_r [Q_FRAC];
  logic [LANES-1:0][TI_W-1:0]   ti_r [Q_FRAC+1];
  logic [LANES-1:0][POW_W-1:0]  r_r  [Q_FRAC];
  logic [LANES-1:0][POW_W-1:0]  pw_r;

  logic [LANES-1:0][Q_FRAC-1:0] tf_in;
  logic [LANES-1:0][TI_W-1:0]   ti_in;
  logic [LANES-1:0][POW_W-1:0]  r_nxt [Q_FRAC];
  logic [LANES-1:0][POW_W-1:0]  pw_nxt;

  // Exponent times negative logarithm, split into integer and fraction.
  always_comb begin
    logic [PW-1:0] prod;
    logic [TW-1:0] t;
    for (int l = 0; l < LANES; l++) begin
      prod     = PW'(p_r[l]) * PW'(lg_r[l]);
      t        = prod[PW-1:EXP_SHIFT];
      tf_in[l] = t[Q_FRAC-1:0];
      ti_in[l] = t[TW-1:Q_FRAC];
    end
  end

  // One conditional multiply by a root of 1/2 per stage.
  always_comb begin
    logic [POW_W-1:0]    rin;
    logic [POW_W+31:0]   rc;
    for (int k = 0; k < Q_FRAC; k++) begin
      for (int l = 0; l < LANES; l++) begin
        rin = (k == 0) ? POW_ONE : r_r[k-1][l];
        rc  = (POW_W + 32)'(rin) * (POW_W + 32)'(EXP_COEF[k]);
        if (tf_r[k][l][Q_FRAC-1-k]) begin
          r_nxt[k][l] = rc[POW_W+31:32];
        end else begin
          r_nxt[k][l] = rin;
        end
      end
    end
  end

  // Apply the integer part of the exponent as a right shift.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (ti_r[Q_FRAC][l] >= TI_W'(POW_ZERO_SHIFT)) begin
        pw_nxt[l] = '0;
      end else begin
        pw_nxt[l] = r_r[Q_FRAC-1][l] >> ti_r[Q_FRAC][l][5:0];
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (en) begin
      lg_r    <= in_lg;
      p_r     <= in_p;
      tf_r[0] <= tf_in;
      ti_r[0] <= ti_in;
      sb_r[0] <= in_sb;
      for (int k = 0; k < Q_FRAC; k++) begin
        r_r[k]    <= r_nxt[k];
        ti_r[k+1] <= ti_r[k];
      end
      for (int k = 0; k < Q_FRAC - 1; k++) begin
        tf_r[k+1] <= tf_r[k];
      end
      for (int s = 0; s < STG - 1; s++) begin
        sb_r[s+1] <= sb_r[s];
      end
      pw_r <= pw_nxt;
    end
  end

  // Valid bits travel with the payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STG-2:0], in_vld};
    end
  end

  assign out_vld = vld_r[STG-1];
  assign out_sb  = sb_r[STG-1];
  assign out_pw  = pw_r;

endmodule

[design/let_relative_permeability_core.sv]
// ----------------------------------------------------------------------------
// LET relative permeability core
// Water and oil relative permeability from one water saturation sample.
// ----------------------------------------------------------------------------
// Usage:
// Registers are written through cfg_ch (index 0..7: water L, E, T, oil L, E,
// T, irreducible water, residual oil); cfg_ch.ready is always high and
// writes to other indexes are dropped. Write them while no request is in
// flight. Samples enter on in_ch, results leave on out_ch, both valid/ready.
// Each request passes the x divider, the 32-step logarithm and power pipelines
// and the final 17-bit divider, in that order. One request is taken per cycle
// while the output is not stalled. The whole pipeline advances as one when the
// output register is empty or being taken; while the receiver stalls with a
// result held, in_ch.ready is low and every stage holds. Reset clears all
// valid bits and the configuration registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module let_relative_permeability_core import lrp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  lrp_cfg_if.sink    cfg_ch,
  lrp_in_if.sink     in_ch,
  lrp_out_if.source  out_ch
);

  localparam int LOG_W = Q_FRAC + $clog2(FRAC_BITS + 1);
  localparam int DEN_W = SAT_W + 1;
  localparam int PRD_W = COEF_W + POW_W;
  localparam int FSB_W = 4;

  logic en;

  // Configuration registers.
  logic [COEF_W-1:0] water_l_r, water_e_r, water_t_r;
  logic [COEF_W-1:0] oil_l_r, oil_e_r, oil_t_r;
  logic [SAT_W-1:0]  swirr_r, sor_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      water_l_r <= '0;
      water_e_r <= '0;
      water_t_r <= '0;
      oil_l_r   <= '0;
      oil_e_r   <= '0;
      oil_t_r   <= '0;
      swirr_r   <= '0;
      sor_r     <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_WATER_L:     water_l_r <= cfg_ch.data;
        REG_WATER_E:     water_e_r <= cfg_ch.data;
        REG_WATER_T:     water_t_r <= cfg_ch.data;
        REG_OIL_L:       oil_l_r   <= cfg_ch.data;
        REG_OIL_E:       oil_e_r   <= cfg_ch.data;
        REG_OIL_T:       oil_t_r   <= cfg_ch.data;
        REG_IRRED_WATER: swirr_r   <= cfg_ch.data;
        REG_RESID_OIL:   sor_r     <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Global advance: the output register is empty or being taken.
  logic out_vld_r;
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // Front stage: span, offset and range classification.
  logic [DEN_W:0]    den_s;
  logic [SAT_W-1:0]  diff_s;
  lrp_class_t        cls_s;

  always_comb begin
    den_s  = (DEN_W + 1)'(65536) - (DEN_W + 1)'(swirr_r) - (DEN_W + 1)'(sor_r);
    diff_s = in_ch.water_saturation - swirr_r;
    if (den_s[DEN_W] || den_s == '0) begin
      cls_s = CLS_DEG;
    end else if (in_ch.water_saturation <= swirr_r) begin
      cls_s = CLS_LOW;
    end else if ({1'b0, diff_s} >= den_s[DEN_W-1:0]) begin
      cls_s = CLS_HIGH;
    end else begin
      cls_s = CLS_MID;
    end
  end

  logic             s0_vld_r;
  lrp_class_t       s0_cls_r;
  logic [SAT_W-1:0] s0_diff_r;
  logic [DEN_W-1:0] s0_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_cls_r  <= cls_s;
      s0_diff_r <= diff_s;
      s0_den_r  <= den_s[DEN_W-1:0];
    end
  end

  // Normalized saturation x = (diff << FRAC_BITS) / den.
  logic                           dx_vld;
  logic [1:0]                     dx_sb;
  logic [0:0][DEN_W-1:0]          dx_rem, dx_div;
  logic [0:0][FRAC_BITS:0]        dx_q;

  assign dx_rem[0] = DEN_W'(s0_diff_r);
  assign dx_div[0] = s0_den_r;

  lrp_div #(
    .LANES (1),
    .DW    (DEN_W),
    .QW    (FRAC_BITS + 1),
    .SB_W  (2)
  ) u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s0_vld_r),
    .in_sb   (s0_cls_r),
    .in_rem  (dx_rem),
    .in_div  (dx_div),
    .out_vld (dx_vld),
    .out_sb  (dx_sb),
    .out_q   (dx_q)
  );

  // A quotient of zero falls back to the low-end result.
  logic [FRAC_BITS-1:0]               x_val;
  lrp_class_t                         cls_x;
  logic [1:0][FRAC_BITS-1:0]          lg_in;

  assign x_val    = dx_q[0][FRAC_BITS-1:0];
  assign cls_x    = (lrp_class_t'(dx_sb) == CLS_MID && x_val == '0) ? CLS_LOW
                                                                    : lrp_class_t'(dx_sb);
  assign lg_in[0] = x_val;
  // y = 1 - x; x is nonzero here so the wrap never matters.
  assign lg_in[1] = FRAC_BITS'(~x_val + FRAC_BITS'(1));

  // Logarithms of x and y.
  logic                     lg_vld;
  logic [1:0]               lg_sb;
  logic [1:0][LOG_W-1:0]    lg_out;

  lrp_log #(
    .LANES (2),
    .FB    (FRAC_BITS),
    .LOG_W (LOG_W),
    .SB_W  (2)
  ) u_log (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (dx_vld),
    .in_sb   (cls_x),
    .in_val  (lg_in),
    .out_vld (lg_vld),
    .out_sb  (lg_sb),
    .out_lg  (lg_out)
  );

  // Four powers: water x^L, y^T; oil y^L, x^T.
  logic [3:0][LOG_W-1:0]  pw_lg;
  logic [3:0][COEF_W-1:0] pw_p;
  logic                   pw_vld;
  logic [1:0]             pw_sb;
  logic [3:0][POW_W-1:0]  pw_out;

  assign pw_lg = {lg_out[0], lg_out[1], lg_out[1], lg_out[0]};
  assign pw_p  = {oil_t_r, oil_l_r, water_t_r, water_l_r};

  lrp_pow #(
    .LANES (4),
    .LOG_W (LOG_W),
    .SB_W  (2)
  ) u_pow (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (lg_vld),
    .in_sb   (lg_sb),
    .in_lg   (pw_lg),
    .in_p    (pw_p),
    .out_vld (pw_vld),
    .out_sb  (pw_sb),
    .out_pw  (pw_out)
  );

  // Weighted second terms E * pow.
  logic [PRD_W-1:0] prod_w, prod_o;
  assign prod_w = PRD_W'(water_e_r) * PRD_W'(pw_out[1]);
  assign prod_o = PRD_W'(oil_e_r) * PRD_W'(pw_out[3]);

  logic              p1_vld_r;
  lrp_class_t        p1_cls_r;
  logic [POW_W-1:0]  num_w_r, num_o_r;
  logic [TERM_W-1:0] term_w_r, term_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= pw_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_cls_r <= lrp_class_t'(pw_sb);
      num_w_r  <= pw_out[0];
      num_o_r  <= pw_out[2];
      term_w_r <= prod_w[PRD_W-1:EXP_SHIFT];
      term_o_r <= prod_o[PRD_W-1:EXP_SHIFT];
    end
  end

  // Final ratio num / (num + term) in Q1.16.
  logic [SUM_W-1:0]         sum_w, sum_o;
  logic [1:0][SUM_W-1:0]    df_rem, df_div;
  logic [FSB_W-1:0]         df_sb_in, df_sb;
  logic                     df_vld;
  logic [1:0][PERM_W-1:0]   df_q;

  assign sum_w     = SUM_W'(num_w_r) + SUM_W'(term_w_r);
  assign sum_o     = SUM_W'(num_o_r) + SUM_W'(term_o_r);
  assign df_rem[0] = SUM_W'(num_w_r);
  assign df_rem[1] = SUM_W'(num_o_r);
  assign df_div[0] = sum_w;
  assign df_div[1] = sum_o;
  assign df_sb_in  = {p1_cls_r, sum_w == '0, sum_o == '0};

  lrp_div #(
    .LANES (2),
    .DW    (SUM_W),
    .QW    (PERM_W),
    .SB_W  (FSB_W)
  ) u_div_f (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (p1_vld_r),
    .in_sb   (df_sb_in),
    .in_rem  (df_rem),
    .in_div  (df_div),
    .out_vld (df_vld),
    .out_sb  (df_sb),
    .out_q   (df_q)
  );

  // Output register: pick the result by class.
  logic [PERM_W-1:0] wperm_r, operm_r;
  logic              deg_r;
  lrp_class_t        f_cls;

  assign f_cls = lrp_class_t'(df_sb[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= df_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (f_cls)
        CLS_DEG: begin
          wperm_r <= '0;
          operm_r <= '0;
          deg_r   <= 1'b1;
        end
        CLS_LOW: begin
          wperm_r <= '0;
          operm_r <= PERM_ONE;
          deg_r   <= 1'b0;
        end
        CLS_HIGH: begin
          wperm_r <= PERM_ONE;
          operm_r <= '0;
          deg_r   <= 1'b0;
        end
        default: begin
          wperm_r <= df_sb[1] ? '0 : df_q[0];
          operm_r <= df_sb[0] ? '0 : df_q[1];
          deg_r   <= 1'b0;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.water_perm = wperm_r;
  assign out_ch.oil_perm   = operm_r;
  assign out_ch.degenerate = deg_r;

  // Checks.
  `LRP_ASSERT(a_deg_zero, out_ch.valid && out_ch.degenerate |-> out_ch.water_perm == '0 && out_ch.oil_perm == '0, "degenerate result carries a nonzero permeability")
  `LRP_ASSERT(a_perm_range, out_ch.valid |-> out_ch.water_perm <= PERM_ONE && out_ch.oil_perm <= PERM_ONE, "permeability above one")
  `LRP_ASSERT(a_stall_hold, !en |=> $stable(s0_vld_r) && $stable(p1_vld_r), "pipeline moved while stalled")
  `LRP_ASSERT_RST(a_rst_empty, !rst_n |=> !out_vld_r && !s0_vld_r && !p1_vld_r, "pipeline not empty after reset")

endmodule

[test/tb_let_relative_permeability_core.sv]
// ----------------------------------------------------------------------------
// LET relative permeability core testbench
// Sends water saturation requests under many register settings. A bit-exact
// fixed-point predictor works out the expected permeabilities, and a checker
// compares each result with the oldest prediction. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_let_relative_permeability_core;
  import lrp_pkg::*;

  localparam int                   WATCHDOG_LIMIT = 4000;
  localparam int                   PIPE_LATENCY   = 109;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED   = CFG_IDX_W'(8);
  localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX  = CFG_IDX_W'(255);

  typedef struct packed {
    logic [PERM_W-1:0] water_perm;
    logic [PERM_W-1:0] oil_perm;
    logic              degenerate;
  } perm_result_t;

  logic clk;
  logic rst_n;

  lrp_cfg_if cfg_ch ();
  lrp_in_if  in_ch ();
  lrp_out_if out_ch ();

  let_relative_permeability_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the register file.
  logic [15:0] shape_reg [8];

  // Halving roots 2^(-2^-k) in Q.32, k = 1..32.
  logic [63:0] half_root [32];

  perm_result_t perm_pending_q[$];
  int           mismatch_count;
  int           burst_mode;
  int           idle_cycles;
  int           rx_stall_left;

  always #6 clk = ~clk;

  // Bitwise integer square root.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] a);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = a;
    root  = '0;
    probe = 64'h1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Minus log2 of a Q0.16 fraction, as Q.32.
  function automatic logic [63:0] minus_log2(input logic [63:0] v);
    logic [63:0] m;
    logic [63:0] whole;
    logic [63:0] frac;
    m     = v << 16;
    whole = 0;
    frac  = 0;
    while (m < (64'h1 << 31)) begin
      m     = m << 1;
      whole = whole + 1;
    end
    for (int i = 0; i < 32; i++) begin
      m    = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'h1 << 32)) begin
        m    = m >> 1;
        frac = frac | 1;
      end
    end
    return ((whole + 1) << 32) - frac;
  endfunction

  // Fraction v raised to the Q4.12 exponent p, as Q.32.
  function automatic logic [63:0] frac_power(input logic [63:0] v, input logic [63:0] p);
    logic [63:0] t;
    logic [63:0] r;
    t = (p * minus_log2(v)) >> 12;
    r = 64'h1 << 32;
    for (int k = 1; k <= 32; k++) begin
      if (t[32-k]) r = (r * half_root[k-1]) >> 32;
    end
    if ((t >> 32) >= 33) return 0;
    return r >> (t >> 32);
  endfunction

  // One LET curve: a^L / (a^L + E * b^T) in Q1.16.
  function automatic logic [PERM_W-1:0] let_ratio(input logic [63:0] a, input logic [63:0] b,
                                                  input logic [15:0] l, input logic [15:0] e,
                                                  input logic [15:0] t);
    logic [63:0] num;
    logic [63:0] sum;
    num = frac_power(a, l);
    sum = num + ((64'(e) * frac_power(b, t)) >> 12);
    if (sum == 0) return '0;
    return PERM_W'((num << 16) / sum);
  endfunction

  function automatic perm_result_t predict_perm(input logic [15:0] sw);
    perm_result_t res;
    int           den;
    logic [63:0]  diff;
    logic [63:0]  x;
    res = '0;
    den = 65536 - int'(shape_reg[REG_IRRED_WATER]) - int'(shape_reg[REG_RESID_OIL]);
    if (den <= 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    if (sw <= shape_reg[REG_IRRED_WATER]) begin
      res.oil_perm = PERM_ONE;
      return res;
    end
    diff = 64'(sw) - 64'(shape_reg[REG_IRRED_WATER]);
    if (diff >= 64'(den)) begin
      res.water_perm = PERM_ONE;
      return res;
    end
    x = (diff << 16) / 64'(den);
    if (x == 0) begin
      res.oil_perm = PERM_ONE;
      return res;
    end
    res.water_perm = let_ratio(x, 65536 - x, shape_reg[REG_WATER_L], shape_reg[REG_WATER_E],
                               shape_reg[REG_WATER_T]);
    res.oil_perm   = let_ratio(65536 - x, x, shape_reg[REG_OIL_L], shape_reg[REG_OIL_E],
                               shape_reg[REG_OIL_T]);
    return res;
  endfunction

  // Register write; unmapped indexes leave the shadow copy alone.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx <= REG_RESID_OIL) shape_reg[idx[2:0]] = value;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [15:0] wl, input logic [15:0] we, input logic [15:0] wt,
                           input logic [15:0] ol, input logic [15:0] oe, input logic [15:0] ot,
                           input logic [15:0] swirr, input logic [15:0] sor);
    write_reg(REG_WATER_L, wl);
    write_reg(REG_WATER_E, we);
    write_reg(REG_WATER_T, wt);
    write_reg(REG_OIL_L, ol);
    write_reg(REG_OIL_E, oe);
    write_reg(REG_OIL_T, ot);
    write_reg(REG_IRRED_WATER, swirr);
    write_reg(REG_RESID_OIL, sor);
  endtask

  // Send one request, after a random gap unless in burst mode; valid stays high into the next one.
  task automatic send_sample(input logic [15:0] sw);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.water_saturation <= sw;
    do @(posedge clk); while (!in_ch.ready);
    perm_pending_q.push_back(predict_perm(sw));
  endtask

  // Wait until every outstanding request has returned.
  task automatic drain();
    if (in_ch.valid) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    while (perm_pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] random_saturation();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'(shape_reg[REG_IRRED_WATER] + $urandom_range(0, 3) - 1);
    if (pick == 1) return 16'(65536 - shape_reg[REG_RESID_OIL] + $urandom_range(0, 3) - 2);
    return 16'($urandom());
  endfunction

  task automatic test_reset_values();
    send_sample(16'h0000);
    send_sample(16'h8000);
    send_sample(16'hFFFF);
    drain();
  endtask

  task automatic test_range_edges();
    write_all(16'd8192, 16'd4096, 16'd8192, 16'd12288, 16'd2048, 16'd4096, 16'd6554, 16'd6554);
    send_sample(16'h0000);
    send_sample(16'd6554);
    send_sample(16'd6555);
    send_sample(16'd32768);
    send_sample(16'd58981);
    send_sample(16'd58982);
    send_sample(16'd58983);
    send_sample(16'hFFFF);
    drain();
  endtask

  // Registers change only once the pipeline is empty.
  task automatic test_degenerate_range();
    write_reg(REG_IRRED_WATER, 16'd40000);
    write_reg(REG_RESID_OIL, 16'd25536);
    send_sample(16'd0);
    send_sample(16'd50000);
    drain();
    write_reg(REG_RESID_OIL, 16'hFFFF);
    send_sample(16'hFFFF);
    drain();
    write_reg(REG_IRRED_WATER, 16'hFFFF);
    send_sample(16'd1);
    drain();
  endtask

  // Zero exponents, a huge exponent that underflows, and an empty sum.
  task automatic test_power_extremes();
    write_all(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0);
    send_sample(16'd1);
    send_sample(16'd30000);
    send_sample(16'hFFFF);
    drain();
    write_all(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    send_sample(16'd1);
    send_sample(16'd2);
    send_sample(16'd65534);
    drain();
  endtask

  task automatic test_unmapped_index();
    write_reg(REG_UNMAPPED, 16'h1234);
    write_reg(REG_TOP_INDEX, 16'hFFFF);
    send_sample(16'd20000);
    send_sample(16'd45000);
    drain();
  endtask

  // Random phases, each with its own register setting and idling mode.
  task automatic test_random_phases();
    int          n_items;
    logic [15:0] swirr;
    for (int phase = 0; phase < 12; phase++) begin
      swirr = 16'($urandom_range(0, 30000));
      if (phase == 0) begin
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
      end else if (phase == 1) begin
        write_all(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd1);
      end else begin
        write_all(16'($urandom_range(1024, 24576)), 16'($urandom()),
                  16'($urandom_range(1024, 24576)), 16'($urandom_range(1024, 24576)),
                  16'($urandom()), 16'($urandom_range(1024, 24576)), swirr,
                  16'($urandom_range(0, ($urandom_range(0, 7) == 0) ? 65535 : 30000)));
      end
      burst_mode = (phase % 3 == 2);
      n_items    = 135;
      for (int i = 0; i < n_items; i++) begin
        send_sample(random_saturation());
        // Hold off the sender once until the pipeline is empty.
        if (phase == 4 && i == 60) drain();
      end
      drain();
    end
    burst_mode = 0;
  endtask

  // Result channel stalls: a random wait before each result is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_stall_left = 0;
      out_ch.ready <= 1'b1;
    end else if (out_ch.valid && out_ch.ready) begin
      rx_stall_left = burst_mode ? 0 : $urandom_range(0, 16);
      out_ch.ready <= (rx_stall_left == 0);
    end else begin
      if (rx_stall_left > 0) rx_stall_left--;
      out_ch.ready <= (rx_stall_left == 0);
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    perm_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (perm_pending_q.size() == 0) begin
        $display("%0t: unexpected result water=%0d oil=%0d degenerate=%0b", $time,
                 out_ch.water_perm, out_ch.oil_perm, out_ch.degenerate);
        mismatch_count++;
      end else begin
        want = perm_pending_q.pop_front();
        if (out_ch.water_perm !== want.water_perm) begin
          $display("%0t: water_perm expected %0d actual %0d", $time, want.water_perm,
                   out_ch.water_perm);
          mismatch_count++;
        end
        if (out_ch.oil_perm !== want.oil_perm) begin
          $display("%0t: oil_perm expected %0d actual %0d", $time, want.oil_perm,
                   out_ch.oil_perm);
          mismatch_count++;
        end
        if (out_ch.degenerate !== want.degenerate) begin
          $display("%0t: degenerate expected %0b actual %0b", $time, want.degenerate,
                   out_ch.degenerate);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on any channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("let_relative_permeability_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] c;
    clk                    = 1'b0;
    rst_n                  = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = '0;
    cfg_ch.data            = '0;
    in_ch.valid            = 1'b0;
    in_ch.water_saturation = '0;
    mismatch_count         = 0;
    burst_mode             = 0;
    idle_cycles            = 0;
    foreach (shape_reg[i]) shape_reg[i] = '0;
    c = floor_sqrt(64'h1 << 63);
    for (int k = 0; k < 32; k++) begin
      half_root[k] = c;
      c            = floor_sqrt(c << 32);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_range_edges();
    test_degenerate_range();
    test_power_extremes();
    test_unmapped_index();
    test_random_phases();

    drain();
    repeat (PIPE_LATENCY + 20) @(posedge clk);
    if (mismatch_count == 0 && perm_pending_q.size() == 0) begin
      $display("let_relative_permeability_core verification clean");
    end else begin
      $display("let_relative_permeability_core verification failed");
    end
    $finish;
  end

endmodule
